// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define BDS_ASSERT_NOW(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define BDS_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

// next-cycle implication, always on
`define BDS_ASSERT_NEXT_ALWAYS(label, clk, a, c) \
  label: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ----- hdl/bds_pkg.sv -----
// shared constants, types and register codes of the 2x bicubic downscaler
// no dependencies
package bds_pkg;

  localparam int MAX_EDGE    = 1024;
  localparam int LINE_ROWS   = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_W       = 11;
  localparam int IDX_W       = 2;
  localparam int CH_W        = 8;
  localparam int NCH         = 4;
  localparam int VSUM_W      = 13;
  localparam int HSUM_W      = 16;

  localparam logic [IDX_W-1:0] REG_EDGE = 2'd0;
  localparam logic [IDX_W-1:0] REG_MODE = 2'd1;

  localparam logic [CFG_W-1:0] EDGE_RESET = 11'd1024;

  typedef enum logic [1:0] {
    POS_LO,
    POS_MID,
    POS_HI
  } pos_t;

  typedef logic signed [VSUM_W-1:0] vsum_t;

  typedef struct packed {
    vsum_t [NCH-1:0] v;
    logic            emit;
    pos_t            hpos;
    logic            last;
    logic            four;
  } col_rec_t;

endpackage

// ----- hdl/bds_fifo.sv -----
// short queue of column records between front and back
// depends on bds_pkg
module bds_fifo #(
  parameter int DEPTH = bds_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  bds_pkg::col_rec_t          push_rec,
  input  logic                       pop,
  output bds_pkg::col_rec_t          head,
  output logic                       nonempty,
  output logic [$clog2(DEPTH+1)-1:0] space
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH+1);

  bds_pkg::col_rec_t q [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CNTW-1:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_rec;
    end
  end

  assign head     = q[rd_ptr];
  assign nonempty = (count != '0);
  assign space    = CNTW'(DEPTH) - count;

endmodule

// ----- hdl/bds_front.sv -----
// front end: registers, position counters, line store and vertical filter
// depends on bds_pkg
module bds_front #(
  parameter int MAX_EDGE = bds_pkg::MAX_EDGE,
  parameter int QUEUE_DEPTH = bds_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [bds_pkg::CH_W-1:0]         chan_a,
  input  logic [bds_pkg::CH_W-1:0]         chan_b,
  input  logic [bds_pkg::CH_W-1:0]         chan_c,
  input  logic [bds_pkg::CH_W-1:0]         chan_d,
  input  logic                             wr_en,
  input  logic [bds_pkg::IDX_W-1:0]        wr_index,
  input  logic [bds_pkg::CFG_W-1:0]        wr_data,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] space,
  output logic                             push,
  output bds_pkg::col_rec_t                push_rec
);

  localparam int CW   = $clog2(MAX_EDGE);
  localparam int EW   = $clog2(MAX_EDGE+1);
  localparam int BW   = $clog2(bds_pkg::LINE_ROWS);
  localparam int PIXW = bds_pkg::CH_W * bds_pkg::NCH;
  localparam int CNTW = $clog2(QUEUE_DEPTH+1);

  function automatic logic [CW-1:0] edge_max_of(input logic [bds_pkg::CFG_W-1:0] v);
    logic [EW-1:0] s;
    logic [EW-1:0] p;
    if (v < bds_pkg::CFG_W'(4)) begin
      s = EW'(4);
    end else if (int'(v) > MAX_EDGE) begin
      s = EW'(MAX_EDGE);
    end else begin
      s = EW'(v);
    end
    p = '0;
    for (int i = 0; i < EW; i++) begin
      if (s[i]) begin
        p = EW'(1) << i;
      end
    end
    return CW'(p - EW'(1));
  endfunction

  function automatic bds_pkg::vsum_t vtap(input logic [bds_pkg::CH_W-1:0] a,
                                          input logic [bds_pkg::CH_W-1:0] b,
                                          input logic [bds_pkg::CH_W-1:0] c,
                                          input logic [bds_pkg::CH_W-1:0] d);
    bds_pkg::vsum_t ea;
    bds_pkg::vsum_t mid;
    bds_pkg::vsum_t ed;
    ea  = $signed({{(bds_pkg::VSUM_W-bds_pkg::CH_W){1'b0}}, a});
    ed  = $signed({{(bds_pkg::VSUM_W-bds_pkg::CH_W){1'b0}}, d});
    mid = $signed({{(bds_pkg::VSUM_W-bds_pkg::CH_W-1){1'b0}}, {1'b0, b} + {1'b0, c}});
    return (mid <<< 2) + mid - ea - ed;
  endfunction

  logic [CW-1:0]  edge_max;
  logic           four;
  logic [CW-1:0]  col;
  logic [CW-1:0]  row;
  logic           accept;
  logic           col_hit;
  logic           row_hit;
  bds_pkg::pos_t  hpos;
  bds_pkg::pos_t  vpos;
  logic [PIXW-1:0] pix;
  logic [PIXW-1:0] rd [bds_pkg::LINE_ROWS];

  logic            s1_valid;
  logic [PIXW-1:0] s1_pix;
  logic [BW-1:0]   s1_bank;
  bds_pkg::pos_t   s1_vpos;
  bds_pkg::pos_t   s1_hpos;
  logic            s1_emit;
  logic            s1_last;
  logic            s1_four;

  logic [PIXW-1:0] m1;
  logic [PIXW-1:0] m2;
  logic [PIXW-1:0] m3;
  logic [PIXW-1:0] y0;
  logic [PIXW-1:0] y1;
  logic [PIXW-1:0] y2;
  logic [PIXW-1:0] y3;

  assign in_stall = (space == '0) || (s1_valid && space == CNTW'(1));
  assign accept   = in_valid && !in_stall;
  assign pix      = {chan_d, chan_c, chan_b, chan_a};

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_max <= edge_max_of(bds_pkg::EDGE_RESET);
      four     <= 1'b1;
      col      <= '0;
      row      <= '0;
    end else if (wr_en && (wr_index == bds_pkg::REG_EDGE || wr_index == bds_pkg::REG_MODE)) begin
      if (wr_index == bds_pkg::REG_EDGE) begin
        edge_max <= edge_max_of(wr_data);
      end else begin
        four <= wr_data[0];
      end
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col == edge_max) begin
        col <= '0;
        row <= (row == edge_max) ? '0 : row + CW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  always_comb begin
    col_hit = (col == edge_max) || (col >= CW'(2) && !col[0]);
    row_hit = (row == edge_max) || (row >= CW'(2) && !row[0]);
    if (col == edge_max) begin
      hpos = bds_pkg::POS_HI;
    end else if (col == CW'(2)) begin
      hpos = bds_pkg::POS_LO;
    end else begin
      hpos = bds_pkg::POS_MID;
    end
    if (row == edge_max) begin
      vpos = bds_pkg::POS_HI;
    end else if (row == CW'(2)) begin
      vpos = bds_pkg::POS_LO;
    end else begin
      vpos = bds_pkg::POS_MID;
    end
  end

  for (genvar b = 0; b < bds_pkg::LINE_ROWS; b++) begin : g_bank
    logic [PIXW-1:0] mem [MAX_EDGE];
    always_ff @(posedge clk) begin
      if (accept && row[BW-1:0] == BW'(b)) begin
        mem[col] <= pix;
      end
      if (accept) begin
        rd[b] <= mem[col];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix  <= pix;
      s1_bank <= row[BW-1:0];
      s1_vpos <= vpos;
      s1_hpos <= hpos;
      s1_emit <= col_hit && row_hit;
      s1_last <= (col == edge_max) && (row == edge_max);
      s1_four <= four;
    end
  end

  // rows above the current one, by age
  always_comb begin
    unique case (s1_bank)
      2'd0: begin
        m1 = rd[3];
        m2 = rd[2];
        m3 = rd[1];
      end
      2'd1: begin
        m1 = rd[0];
        m2 = rd[3];
        m3 = rd[2];
      end
      2'd2: begin
        m1 = rd[1];
        m2 = rd[0];
        m3 = rd[3];
      end
      default: begin
        m1 = rd[2];
        m2 = rd[1];
        m3 = rd[0];
      end
    endcase
  end

  // border clamping of the vertical taps
  always_comb begin
    unique case (s1_vpos)
      bds_pkg::POS_LO: begin
        y0 = m2;
        y1 = m2;
        y2 = m1;
        y3 = s1_pix;
      end
      bds_pkg::POS_HI: begin
        y0 = m2;
        y1 = m1;
        y2 = s1_pix;
        y3 = s1_pix;
      end
      default: begin
        y0 = m3;
        y1 = m2;
        y2 = m1;
        y3 = s1_pix;
      end
    endcase
  end

  always_comb begin
    push          = s1_valid;
    push_rec.emit = s1_emit;
    push_rec.hpos = s1_hpos;
    push_rec.last = s1_last;
    push_rec.four = s1_four;
    for (int ch = 0; ch < bds_pkg::NCH; ch++) begin
      push_rec.v[ch] = vtap(y0[ch*bds_pkg::CH_W +: bds_pkg::CH_W],
                            y1[ch*bds_pkg::CH_W +: bds_pkg::CH_W],
                            y2[ch*bds_pkg::CH_W +: bds_pkg::CH_W],
                            y3[ch*bds_pkg::CH_W +: bds_pkg::CH_W]);
    end
  end

endmodule

// ----- hdl/bds_back.sv -----
// back end: horizontal filter over column sums, saturation, output register
// depends on bds_pkg
module bds_back (
  input  logic                     clk,
  input  logic                     rst,
  input  bds_pkg::col_rec_t        head,
  input  logic                     nonempty,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [bds_pkg::CH_W-1:0] out_a,
  output logic [bds_pkg::CH_W-1:0] out_b,
  output logic [bds_pkg::CH_W-1:0] out_c,
  output logic [bds_pkg::CH_W-1:0] out_d,
  output logic                     frame_end
);

  localparam int HW = bds_pkg::HSUM_W;
  localparam int CH = bds_pkg::CH_W;

  function automatic logic [CH-1:0] hfilt(input bds_pkg::vsum_t a,
                                          input bds_pkg::vsum_t b,
                                          input bds_pkg::vsum_t c,
                                          input bds_pkg::vsum_t d);
    logic signed [HW-1:0] mid;
    logic signed [HW-1:0] sum;
    logic [CH-1:0]        r;
    mid = HW'(b) + HW'(c);
    sum = (mid <<< 2) + mid - HW'(a) - HW'(d);
    if (sum[HW-1]) begin
      r = '0;
    end else if (|sum[HW-2:CH+6]) begin
      r = '1;
    end else begin
      r = sum[CH+5:6];
    end
    return r;
  endfunction

  bds_pkg::vsum_t [bds_pkg::NCH-1:0] win [3];
  bds_pkg::vsum_t [bds_pkg::NCH-1:0] h0;
  bds_pkg::vsum_t [bds_pkg::NCH-1:0] h1;
  bds_pkg::vsum_t [bds_pkg::NCH-1:0] h2;
  bds_pkg::vsum_t [bds_pkg::NCH-1:0] h3;
  logic [bds_pkg::NCH-1:0][CH-1:0]   res;
  logic                              out_free;

  assign out_free = !out_valid || !out_stall;
  assign pop      = nonempty && (!head.emit || out_free);

  // border clamping of the horizontal taps
  always_comb begin
    unique case (head.hpos)
      bds_pkg::POS_LO: begin
        h0 = win[1];
        h1 = win[1];
        h2 = win[2];
        h3 = head.v;
      end
      bds_pkg::POS_HI: begin
        h0 = win[1];
        h1 = win[2];
        h2 = head.v;
        h3 = head.v;
      end
      default: begin
        h0 = win[0];
        h1 = win[1];
        h2 = win[2];
        h3 = head.v;
      end
    endcase
    for (int ch = 0; ch < bds_pkg::NCH; ch++) begin
      res[ch] = hfilt(h0[ch], h1[ch], h2[ch], h3[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= head.v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.emit) begin
      out_a     <= res[0];
      out_b     <= head.four ? res[1] : '0;
      out_c     <= head.four ? res[2] : '0;
      out_d     <= head.four ? res[3] : '0;
      frame_end <= head.last;
    end
  end

endmodule

// ----- hdl/bicubic_downscale_2x.sv -----
// top level of the 2x bicubic downscaler
// depends on bds_pkg, bds_front, bds_fifo, bds_back
//
// input channel: one pixel per item (chan_a..chan_d) in raster order of a square
// frame, taken when in_valid is high and in_stall low. output channel: one
// downscaled pixel per item (out_a..out_d, frame_end on the last one of a frame),
// taken when out_valid is high and out_stall low.
// registers: wr_en, wr_index, wr_data; index 0 sets the edge, index 1 the
// four-channel mode; either write restarts the frame at pixel zero.
// throughput: one pixel per cycle while in_stall is low; for each pixel taken the
// line store writes the current row's bank and reads every bank at its column.
// a pixel that completes an output passes the line store stage and the queue,
// then is registered into the output register that drives out_valid.
// while out_stall holds, column records collect in the queue between the line
// store stage and the horizontal filter; in_stall rises once the queue has no
// room left for the record still in the line store stage.
// reset: edge 1024, four-channel mode, position zero, queue and output empty;
// the line store is not cleared and is only read where written this frame.
module bicubic_downscale_2x #(
  parameter int MAX_EDGE    = bds_pkg::MAX_EDGE,
  parameter int QUEUE_DEPTH = bds_pkg::QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [bds_pkg::CH_W-1:0]  chan_a,
  input  logic [bds_pkg::CH_W-1:0]  chan_b,
  input  logic [bds_pkg::CH_W-1:0]  chan_c,
  input  logic [bds_pkg::CH_W-1:0]  chan_d,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [bds_pkg::CH_W-1:0]  out_a,
  output logic [bds_pkg::CH_W-1:0]  out_b,
  output logic [bds_pkg::CH_W-1:0]  out_c,
  output logic [bds_pkg::CH_W-1:0]  out_d,
  output logic                      frame_end,
  input  logic                      wr_en,
  input  logic [bds_pkg::IDX_W-1:0] wr_index,
  input  logic [bds_pkg::CFG_W-1:0] wr_data
);

  logic                             push;
  bds_pkg::col_rec_t                push_rec;
  logic                             pop;
  bds_pkg::col_rec_t                head;
  logic                             nonempty;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] space;

  bds_front #(
    .MAX_EDGE    (MAX_EDGE),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .chan_a   (chan_a),
    .chan_b   (chan_b),
    .chan_c   (chan_c),
    .chan_d   (chan_d),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .space    (space),
    .push     (push),
    .push_rec (push_rec)
  );

  bds_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .nonempty (nonempty),
    .space    (space)
  );

  bds_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .nonempty  (nonempty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_a     (out_a),
    .out_b     (out_b),
    .out_c     (out_c),
    .out_d     (out_d),
    .frame_end (frame_end)
  );

endmodule

// ----- hdl/bds_checker.sv -----
// port-level checks of the 2x bicubic downscaler, bound to the top level
// depends on bds_pkg, assert_macros.svh, bicubic_downscale_2x
`include "assert_macros.svh"

module bds_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [bds_pkg::CH_W-1:0]  chan_a,
  input logic [bds_pkg::CH_W-1:0]  chan_b,
  input logic [bds_pkg::CH_W-1:0]  chan_c,
  input logic [bds_pkg::CH_W-1:0]  chan_d,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [bds_pkg::CH_W-1:0]  out_a,
  input logic [bds_pkg::CH_W-1:0]  out_b,
  input logic [bds_pkg::CH_W-1:0]  out_c,
  input logic [bds_pkg::CH_W-1:0]  out_d,
  input logic                      frame_end,
  input logic                      wr_en,
  input logic [bds_pkg::IDX_W-1:0] wr_index,
  input logic [bds_pkg::CFG_W-1:0] wr_data
);

  // stalled result holds
  `BDS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_a) && $stable(out_b) && $stable(out_c) && $stable(out_d) && $stable(frame_end))

  // reset empties the output register
  `BDS_ASSERT_NEXT_ALWAYS(a_rst_out, clk, rst, !out_valid)

  // reset leaves the queue with room for the next item
  `BDS_ASSERT_NEXT_ALWAYS(a_rst_ready, clk, rst, !in_stall)

  // the queue only fills while a result waits at the output
  `BDS_ASSERT_NOW(a_stall_src, clk, rst, in_stall && !$past(in_stall) && !$past(rst), $past(out_valid && out_stall) || (out_valid && out_stall))

endmodule

bind bicubic_downscale_2x bds_checker u_bds_checker (.*);
